/* src/sua_pkg.sv */
package sua_pkg;

  localparam int MAX_SEQ_BYTES = 4;
  localparam int SENDER_W      = 22;
  localparam int BITS_PER_BYTE = 8;

  localparam logic [7:0] LEAD2_MIN = 8'd192;
  localparam logic [7:0] LEAD3_MIN = 8'd224;
  localparam logic [7:0] LEAD4_MIN = 8'd240;

  typedef logic [7:0]          byte_t;
  typedef logic [2:0]          len_t;
  typedef logic [SENDER_W-1:0] sender_t;

  typedef struct packed {
    byte_t byte_first;
    byte_t byte_second;
    byte_t byte_third;
    byte_t byte_fourth;
    len_t  char_length;
  } char_t;

  // Sequence length implied by the lead byte of a character.
  function automatic len_t lead_length(input byte_t b);
    len_t len;
    if (b < LEAD2_MIN) begin
      len = 3'd1;
    end else if (b < LEAD3_MIN) begin
      len = 3'd2;
    end else if (b < LEAD4_MIN) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

/* src/sua_bit_if.sv */
interface sua_bit_if;
  import sua_pkg::*;

  logic    valid;
  logic    ready;
  logic    bit_value;
  sender_t sender_id;

  modport source (output valid, output bit_value, output sender_id, input ready);
  modport sink   (input valid, input bit_value, input sender_id, output ready);
endinterface

/* src/sua_char_if.sv */
interface sua_char_if;
  import sua_pkg::*;

  logic  valid;
  logic  ready;
  byte_t byte_first;
  byte_t byte_second;
  byte_t byte_third;
  byte_t byte_fourth;
  len_t  char_length;

  modport source (
    output valid, output byte_first, output byte_second, output byte_third,
    output byte_fourth, output char_length, input ready
  );
  modport sink (
    input valid, input byte_first, input byte_second, input byte_third,
    input byte_fourth, input char_length, output ready
  );
endinterface

/* src/serial_utf8_char_assembler.sv */
// Serial UTF-8 character assembler.
// bit_stream carries one received bit per request together with the id of
// its sender; bits are shifted in most significant first, eight to a byte.
// The lead byte of a character sets its length (one to four bytes), and once
// all bytes are in, char_stream carries one request with the bytes and the
// length; unused byte slots are zero. A lone null byte produces nothing.
// A change of sender id drops the partial byte and the partial character.
// A bit request is taken in every cycle unless the skid stage is full; a
// finished character goes into the output stage. Throughput is one bit per
// cycle while the skid stage is empty, set by the single state update per bit.
// When the receiver stalls, a skid stage holds one more character and
// bit_stream keeps accepting; ready drops only while that stage is full.
// Synchronous reset clears the partial byte, partial character, current
// sender and both output stages; no reset pass is needed.
module serial_utf8_char_assembler (
  input  logic       clk,
  input  logic       rst,
  sua_bit_if.sink    bit_stream,
  sua_char_if.source char_stream
);
  import sua_pkg::*;

  logic    [7:0] shift_byte;
  logic    [2:0] bit_count;
  sender_t       current_sender;
  byte_t         char_bytes [MAX_SEQ_BYTES];
  len_t          byte_index;
  len_t          expected_length;
  logic          sequence_started;

  logic    [7:0] shift_byte_next;
  logic    [2:0] bit_count_next;
  byte_t         char_bytes_next [MAX_SEQ_BYTES];
  len_t          byte_index_next;
  len_t          expected_length_next;
  logic          sequence_started_next;

  logic    accept;
  logic    push_ready;
  logic    push;
  char_t   push_data;

  logic    sender_change;
  logic    [7:0] sb_cur;
  logic    [2:0] bc_cur;
  byte_t   cb_cur [MAX_SEQ_BYTES];
  len_t    idx_cur;
  len_t    exp_cur;
  logic    started_cur;
  byte_t   new_byte;
  logic    byte_done;
  len_t    exp_eff;
  logic    do_store;
  byte_t   cb_upd [MAX_SEQ_BYTES];
  len_t    idx_upd;
  logic    char_done;
  logic    lone_null;

  assign accept           = bit_stream.valid && push_ready;
  assign bit_stream.ready = push_ready;

  // Zero means no sender has been seen yet; the first id is simply taken.
  assign sender_change = (current_sender != '0) && (current_sender != bit_stream.sender_id);

  always_comb begin
    sb_cur      = sender_change ? '0 : shift_byte;
    bc_cur      = sender_change ? '0 : bit_count;
    idx_cur     = sender_change ? '0 : byte_index;
    exp_cur     = sender_change ? '0 : expected_length;
    started_cur = sender_change ? 1'b0 : sequence_started;
    for (int k = 0; k < MAX_SEQ_BYTES; k++) begin
      cb_cur[k] = sender_change ? '0 : char_bytes[k];
    end

    new_byte  = {sb_cur[6:0], bit_stream.bit_value};
    byte_done = (bc_cur == 3'(BITS_PER_BYTE - 1));
    exp_eff   = started_cur ? exp_cur : lead_length(new_byte);
    do_store  = idx_cur < exp_eff;
    for (int k = 0; k < MAX_SEQ_BYTES; k++) begin
      cb_upd[k] = (do_store && idx_cur == 3'(k)) ? new_byte : cb_cur[k];
    end
    idx_upd   = do_store ? idx_cur + 3'd1 : idx_cur;
    char_done = byte_done && (idx_upd >= exp_eff);
    lone_null = (exp_eff == 3'd1) && (cb_upd[0] == '0);

    shift_byte_next       = byte_done ? '0 : new_byte;
    bit_count_next        = byte_done ? '0 : bc_cur + 3'd1;
    byte_index_next       = idx_cur;
    expected_length_next  = exp_cur;
    sequence_started_next = started_cur;
    for (int k = 0; k < MAX_SEQ_BYTES; k++) begin
      char_bytes_next[k] = cb_cur[k];
    end
    if (char_done) begin
      byte_index_next       = '0;
      expected_length_next  = '0;
      sequence_started_next = 1'b0;
      for (int k = 0; k < MAX_SEQ_BYTES; k++) begin
        char_bytes_next[k] = '0;
      end
    end else if (byte_done) begin
      byte_index_next       = idx_upd;
      expected_length_next  = exp_eff;
      sequence_started_next = 1'b1;
      for (int k = 0; k < MAX_SEQ_BYTES; k++) begin
        char_bytes_next[k] = cb_upd[k];
      end
    end

    push                  = accept && char_done && !lone_null;
    push_data.byte_first  = cb_upd[0];
    push_data.byte_second = cb_upd[1];
    push_data.byte_third  = cb_upd[2];
    push_data.byte_fourth = cb_upd[3];
    push_data.char_length = exp_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_byte       <= '0;
      bit_count        <= '0;
      current_sender   <= '0;
      byte_index       <= '0;
      expected_length  <= '0;
      sequence_started <= 1'b0;
      for (int k = 0; k < MAX_SEQ_BYTES; k++) begin
        char_bytes[k] <= '0;
      end
    end else if (accept) begin
      shift_byte       <= shift_byte_next;
      bit_count        <= bit_count_next;
      current_sender   <= bit_stream.sender_id;
      byte_index       <= byte_index_next;
      expected_length  <= expected_length_next;
      sequence_started <= sequence_started_next;
      for (int k = 0; k < MAX_SEQ_BYTES; k++) begin
        char_bytes[k] <= char_bytes_next[k];
      end
    end
  end

  sua_out_skid u_out_skid (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_data   (push_data),
    .push_ready  (push_ready),
    .char_stream (char_stream)
  );

endmodule

/* src/sua_out_skid.sv */
module sua_out_skid (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sua_pkg::char_t push_data,
  output logic           push_ready,
  sua_char_if.source     char_stream
);
  import sua_pkg::*;

  logic  out_valid;
  char_t out_data;
  logic  skid_valid;
  char_t skid_data;

  // The skid stage catches one request while the receiver stalls.
  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || char_stream.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        out_data  <= push_data;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

  assign char_stream.valid       = out_valid;
  assign char_stream.byte_first  = out_data.byte_first;
  assign char_stream.byte_second = out_data.byte_second;
  assign char_stream.byte_third  = out_data.byte_third;
  assign char_stream.byte_fourth = out_data.byte_fourth;
  assign char_stream.char_length = out_data.char_length;

endmodule

/* dv/sua_char_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the assembler, predicts every character from the
// accepted bit requests and compares each character request against the
// oldest prediction.
module sua_char_checker (
  input  logic clk,
  input  logic rst,
  sua_bit_if   bit_mon,
  sua_char_if  char_mon,
  output int   fail_count,
  output int   pending
);
  import sua_pkg::*;

  char_t expected_chars[$];

  // Predicted assembler state.
  byte_t   shift_reg;
  int      bits_in;
  sender_t sender_now;
  byte_t   got_bytes[MAX_SEQ_BYTES];
  int      got;
  int      want_len;
  logic    in_char;

  function automatic int seq_len(input byte_t lead);
    return (lead >= LEAD4_MIN) ? 4 : (lead >= LEAD3_MIN) ? 3 : (lead >= LEAD2_MIN) ? 2 : 1;
  endfunction

  task automatic drop_char();
    foreach (got_bytes[i]) got_bytes[i] = '0;
    got = 0;
    want_len = 0;
    in_char = 1'b0;
    shift_reg = '0;
  endtask

  task automatic take_bit(input logic b, input sender_t sid);
    byte_t full;
    char_t c;
    if (sender_now == '0) begin
      sender_now = sid;
    end else if (sender_now != sid) begin
      // A new sender throws away whatever was in flight.
      sender_now = sid;
      drop_char();
      bits_in = 0;
    end
    shift_reg = {shift_reg[6:0], b};
    bits_in++;
    if (bits_in < BITS_PER_BYTE) return;
    full = shift_reg;
    shift_reg = '0;
    bits_in = 0;
    if (!in_char) begin
      want_len = seq_len(full);
      in_char = 1'b1;
    end
    if (got < want_len && got < MAX_SEQ_BYTES) begin
      got_bytes[got] = full;
      got++;
    end
    if (got < want_len) return;
    // A single null byte ends the character silently.
    if (want_len == 1 && got_bytes[0] == 8'h00) begin
      drop_char();
      return;
    end
    c.byte_first  = got_bytes[0];
    c.byte_second = got_bytes[1];
    c.byte_third  = got_bytes[2];
    c.byte_fourth = got_bytes[3];
    c.char_length = len_t'(want_len);
    expected_chars.push_back(c);
    drop_char();
  endtask

  task automatic check_field(input string name, input int want, input int seen);
    if (want != seen) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    char_t want;
    if (rst) begin
      drop_char();
      bits_in = 0;
      sender_now = '0;
      expected_chars.delete();
    end else begin
      if (bit_mon.valid && bit_mon.ready) begin
        take_bit(bit_mon.bit_value, bit_mon.sender_id);
      end
      if (char_mon.valid && char_mon.ready) begin
        if (expected_chars.size() == 0) begin
          $error("character request with none expected: %h %h %h %h length %0d",
                 char_mon.byte_first, char_mon.byte_second, char_mon.byte_third,
                 char_mon.byte_fourth, char_mon.char_length);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          check_field("byte_first", want.byte_first, char_mon.byte_first);
          check_field("byte_second", want.byte_second, char_mon.byte_second);
          check_field("byte_third", want.byte_third, char_mon.byte_third);
          check_field("byte_fourth", want.byte_fourth, char_mon.byte_fourth);
          check_field("char_length", want.char_length, char_mon.char_length);
        end
      end
    end
    pending = expected_chars.size();
  end

endmodule

/* dv/tb_serial_utf8_char_assembler.sv */
`timescale 1ns / 100ps

module tb_serial_utf8_char_assembler;
  import sua_pkg::*;

  logic clk = 1'b0;
  logic rst;

  int fail_count;
  int pending;
  int idle_pct;
  int stall_pct;
  int bits_sent;
  sender_t cur_sender;

  sua_bit_if  bit_if ();
  sua_char_if char_if ();

  serial_utf8_char_assembler dut (
    .clk         (clk),
    .rst         (rst),
    .bit_stream  (bit_if),
    .char_stream (char_if)
  );

  sua_char_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .bit_mon    (bit_if),
    .char_mon   (char_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    char_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Called and returning at a falling edge; the request is held until taken.
  task automatic send_bit(input logic b, input sender_t sid);
    while ($urandom_range(99) < idle_pct) begin
      bit_if.valid <= 1'b0;
      @(negedge clk);
    end
    bit_if.valid     <= 1'b1;
    bit_if.bit_value <= b;
    bit_if.sender_id <= sid;
    do @(posedge clk); while (!bit_if.ready);
    bits_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(input byte_t v, input sender_t sid);
    for (int i = 7; i >= 0; i--) send_bit(v[i], sid);
  endtask

  function automatic sender_t next_sender();
    sender_t s;
    do begin
      case ($urandom_range(3))
        0:       s = sender_t'(1);
        1:       s = '1;
        default: s = sender_t'($urandom_range(1, 4194303));
      endcase
    end while (s == cur_sender);
    return s;
  endfunction

  // Sends one character with a lead byte from a random length class; when cut
  // is set, the character stops short somewhere inside.
  task automatic send_char(input sender_t sid, input bit cut);
    byte_t seq[MAX_SEQ_BYTES];
    int n, limit, sel;
    sel = $urandom_range(9);
    if (sel == 0) begin
      seq[0] = 8'h00;
      n = 1;
    end else if (sel <= 3) begin
      seq[0] = byte_t'($urandom_range(1, 191));
      n = 1;
    end else if (sel <= 5) begin
      seq[0] = byte_t'($urandom_range(192, 223));
      n = 2;
    end else if (sel <= 7) begin
      seq[0] = byte_t'($urandom_range(224, 239));
      n = 3;
    end else begin
      seq[0] = byte_t'($urandom_range(240, 255));
      n = 4;
    end
    for (int i = 1; i < MAX_SEQ_BYTES; i++) begin
      seq[i] = ($urandom_range(7) == 0) ? 8'h00 : byte_t'($urandom_range(255));
    end
    limit = cut ? $urandom_range(1, 8 * n - 1) : 8 * n;
    for (int k = 0; k < limit; k++) send_bit(seq[k / 8][7 - k % 8], sid);
  endtask

  task automatic run_random(input int count);
    int stop_at, sel, n;
    stop_at = bits_sent + count;
    while (bits_sent < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 8) cur_sender = next_sender();
      if (sel < 78) begin
        send_char(cur_sender, 1'b0);
      end else if (sel < 90) begin
        send_char(cur_sender, 1'b1);
        cur_sender = next_sender();
      end else begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
          send_bit(1'($urandom_range(1)), $urandom_range(1) ? cur_sender : next_sender());
        end
        cur_sender = next_sender();
      end
    end
  endtask

  task automatic drain();
    bit_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    bit_if.valid = 1'b0;
    bit_if.bit_value = 1'b0;
    bit_if.sender_id = sender_t'(1);
    char_if.ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    bits_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The first sender is adopted; a partial byte is then dropped by a new
    // sender, a lone null byte yields nothing, and a null may follow a lead.
    send_bit(1'b1, sender_t'(1));
    send_bit(1'b0, sender_t'(1));
    send_bit(1'b1, sender_t'(1));
    cur_sender = '1;
    send_byte(8'h00, cur_sender);
    send_byte(8'hC0, cur_sender);
    send_byte(8'h00, cur_sender);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      run_random(480);
      // Hold the sender back until every predicted character has come out.
      drain();
    end

    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_serial_utf8_char_assembler passed");
    end else begin
      $display("tb_serial_utf8_char_assembler failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_serial_utf8_char_assembler failed");
    $finish;
  end

endmodule

/* sim.f */
src/sua_pkg.sv
src/sua_bit_if.sv
src/sua_char_if.sv
src/sua_out_skid.sv
src/serial_utf8_char_assembler.sv
dv/sua_char_checker.sv
dv/tb_serial_utf8_char_assembler.sv
